// File: design/lgbc_pkg.sv
package lgbc_pkg;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int LABEL_W   = 9;
  localparam int QUERY_W   = 8;
  localparam int COUNT_W   = 12;
  localparam int LANES     = 3;

  localparam logic [LABEL_W-1:0] UNLABELED = 9'h1FF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 12'hFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef logic [LANES-1:0][LABEL_W-1:0] col_t;

endpackage

// File: design/label_grid_border_counter.sv
// Channel  Handshake                   Payload
// in       in_valid_i / in_stall_o     op_i, cell_label_i, query_label_i
// out      out_valid_o / out_stall_i   border_count_o, grid_complete_o
// cfg      cfg_we_i                    cfg_idx_i, cfg_data_i
//
// A push that closes a row (from the third row on) runs a pass over the row memory:
// one column word read per cycle plus the histogram read-modify-write tail. A read
// holds the block in ST_QRY until its result is loaded; a clear runs a histogram
// clearing pass over all MAX_LABELS entries, and reset starts such a pass too.
// in_stall_o is high whenever the block is not idle; a waiting result stalls the
// next read in ST_QRY and so holds back all input behind it, pushes too.
module label_grid_border_counter #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int MAX_LABELS = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           op_i,
  input  logic signed [lgbc_pkg::LABEL_W-1:0]  cell_label_i,
  input  logic [lgbc_pkg::QUERY_W-1:0]         query_label_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lgbc_pkg::COUNT_W-1:0]         border_count_o,
  output logic                                 grid_complete_o,
  input  logic                                 cfg_we_i,
  input  logic [lgbc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lgbc_pkg::CFG_W-1:0]           cfg_data_i
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int LW = $clog2(MAX_LABELS);
  localparam int KW = lgbc_pkg::CFG_W + 1;

  localparam logic [6:0] ROW_CAP = (MAX_ROWS > 127) ? 7'd127 : 7'(MAX_ROWS);
  localparam logic [6:0] COL_CAP = (MAX_COLS > 127) ? 7'd127 : 7'(MAX_COLS);
  localparam logic [6:0] ROW_RST = (MAX_ROWS < 64) ? 7'(MAX_ROWS) : 7'd64;
  localparam logic [6:0] COL_RST = (MAX_COLS < 64) ? 7'(MAX_COLS) : 7'd64;
  localparam logic [LW-1:0] LAST_LABEL = LW'(MAX_LABELS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_QRY  = 2'd2;
  localparam logic [1:0] ST_CLR  = 2'd3;

  // control state
  logic [1:0]  state_q, state_d;
  logic [6:0]  num_rows_q, num_rows_d;
  logic [6:0]  num_cols_q, num_cols_d;
  logic [6:0]  cur_row_q, cur_row_d;
  logic [6:0]  cur_col_q, cur_col_d;
  logic [1:0]  slot_q, slot_d;
  logic [KW-1:0] rd_k_q, rd_k_d;
  logic        rd_vld_q;
  logic [KW-1:0] rd_j_q;
  logic        cand_vld_q, cand_vld_d;
  logic        hrd_vld_q;
  logic        wr_vld_q;
  logic [LW-1:0] clr_addr_q, clr_addr_d;
  logic        out_valid_q, out_valid_d;

  // payload
  logic [CW-1:0]  dummy_unused_cw;
  logic [LW-1:0]  cand_lab_q, cand_lab_d;
  logic [LW-1:0]  hrd_lab_q;
  logic [LW-1:0]  wr_lab_q;
  logic [lgbc_pkg::COUNT_W-1:0] wr_data_q;
  logic        qry_ok_q;
  lgbc_pkg::col_t win_l_q, win_c_q;
  lgbc_pkg::col_t row_rdata_q;
  logic [lgbc_pkg::COUNT_W-1:0] hist_rdata_q;
  logic [lgbc_pkg::COUNT_W-1:0] border_count_q;
  logic        grid_complete_q;

  // memories
  lgbc_pkg::col_t row_mem [MAX_COLS];
  logic [lgbc_pkg::COUNT_W-1:0] hist_mem [MAX_LABELS];

  // datapath signals
  logic        in_acc, is_push, is_read, is_clear, cfg_hit, grid_full, push_ok;
  logic        row_end, start_eval, rd_issue, ev_now, border, countable, out_load;
  logic [lgbc_pkg::LABEL_W-1:0] push_lab, lab;
  logic [KW-1:0] col_next, ncols_k, rd_col_k;
  logic [CW+6:0] wcol_ext, rcol_ext;
  logic [CW-1:0] row_waddr, row_raddr;
  logic [1:0]  up_s, mid_s, dn_s;
  logic [LW+lgbc_pkg::LABEL_W-1:0] lab_ext;
  logic [LW+lgbc_pkg::QUERY_W-1:0] q_ext;
  logic [LW-1:0] q_addr;
  logic        hist_re, hist_we;
  logic [LW-1:0] hist_raddr, hist_waddr;
  logic [lgbc_pkg::COUNT_W-1:0] cur_cnt, inc_cnt, hist_wdata;
  logic [6:0]  cfg_rows, cfg_cols;

  assign dummy_unused_cw = row_raddr ^ row_waddr;

  always_comb begin
    in_acc     = in_valid_i && !in_stall_o;
    is_push    = in_acc && (op_i == lgbc_pkg::OP_PUSH);
    is_read    = in_acc && (op_i == lgbc_pkg::OP_READ);
    is_clear   = in_acc && (op_i == lgbc_pkg::OP_CLEAR);
    cfg_hit    = cfg_we_i && ((cfg_idx_i == lgbc_pkg::CFG_NUM_ROWS) ||
                              (cfg_idx_i == lgbc_pkg::CFG_NUM_COLS));
    push_lab   = cell_label_i[lgbc_pkg::LABEL_W-1] ? lgbc_pkg::UNLABELED
                                                    : $unsigned(cell_label_i);
    grid_full  = cur_row_q >= num_rows_q;
    push_ok    = is_push && !grid_full;
    col_next   = {1'b0, cur_col_q} + KW'(1);
    ncols_k    = {1'b0, num_cols_q};
    row_end    = col_next >= ncols_k;
    start_eval = push_ok && row_end && (cur_row_q >= 7'd2);

    // column sweep: last column, then 0 .. N-1, then column 0 again
    rd_issue = (state_q == ST_EVAL) && (rd_k_q <= ncols_k + KW'(1));
    if (rd_k_q == '0) begin
      rd_col_k = ncols_k - KW'(1);
    end else if (rd_k_q == ncols_k + KW'(1)) begin
      rd_col_k = '0;
    end else begin
      rd_col_k = rd_k_q - KW'(1);
    end
    wcol_ext  = {{CW{1'b0}}, cur_col_q};
    rcol_ext  = {{CW{1'b0}}, rd_col_k[6:0]};
    row_waddr = wcol_ext[CW-1:0];
    row_raddr = rcol_ext[CW-1:0];

    up_s  = slot_q;
    mid_s = (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
    dn_s  = (slot_q == 2'd0) ? 2'd2 : slot_q - 2'd1;

    ev_now = rd_vld_q && (rd_j_q >= KW'(2));
    lab    = win_c_q[mid_s];
    border = (lab != win_l_q[up_s])  || (lab != win_c_q[up_s])  ||
             (lab != row_rdata_q[up_s]) || (lab != win_l_q[mid_s]) ||
             (lab != row_rdata_q[mid_s]) || (lab != win_l_q[dn_s]) ||
             (lab != win_c_q[dn_s])  || (lab != row_rdata_q[dn_s]);
    countable  = (lab != lgbc_pkg::UNLABELED) && (32'(lab) < MAX_LABELS);
    lab_ext    = {{LW{1'b0}}, lab};
    cand_vld_d = ev_now && border && countable;
    cand_lab_d = lab_ext[LW-1:0];

    q_ext  = {{LW{1'b0}}, query_label_i};
    q_addr = q_ext[LW-1:0];

    hist_re    = cand_vld_q || is_read;
    hist_raddr = cand_vld_q ? cand_lab_q : q_addr;
    cur_cnt    = (wr_vld_q && (wr_lab_q == hrd_lab_q)) ? wr_data_q : hist_rdata_q;
    inc_cnt    = (cur_cnt == lgbc_pkg::COUNT_MAX) ? cur_cnt
                                                   : cur_cnt + lgbc_pkg::COUNT_W'(1);
    hist_we    = (state_q == ST_CLR) || hrd_vld_q;
    hist_waddr = (state_q == ST_CLR) ? clr_addr_q : hrd_lab_q;
    hist_wdata = (state_q == ST_CLR) ? '0 : inc_cnt;

    out_load = (state_q == ST_QRY) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    cfg_rows = cfg_data_i;
    if (cfg_data_i < 7'd3) begin
      cfg_rows = 7'd3;
    end else if (cfg_data_i > ROW_CAP) begin
      cfg_rows = ROW_CAP;
    end
    cfg_cols = cfg_data_i;
    if (cfg_data_i < 7'd2) begin
      cfg_cols = 7'd2;
    end else if (cfg_data_i > COL_CAP) begin
      cfg_cols = COL_CAP;
    end
  end

  always_comb begin
    state_d     = state_q;
    num_rows_d  = num_rows_q;
    num_cols_d  = num_cols_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    slot_d      = slot_q;
    rd_k_d      = rd_k_q;
    clr_addr_d  = clr_addr_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (is_read) begin
          state_d = ST_QRY;
        end else if (is_clear) begin
          state_d    = ST_CLR;
          clr_addr_d = '0;
          cur_row_d  = '0;
          cur_col_d  = '0;
          slot_d     = '0;
        end else if (push_ok) begin
          if (row_end) begin
            cur_col_d = '0;
            cur_row_d = cur_row_q + 7'd1;
            slot_d    = (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
          end else begin
            cur_col_d = col_next[6:0];
          end
          if (start_eval) begin
            state_d = ST_EVAL;
            rd_k_d  = '0;
          end
        end
      end
      ST_EVAL: begin
        if (rd_issue) begin
          rd_k_d = rd_k_q + KW'(1);
        end else if (!rd_vld_q && !cand_vld_q && !hrd_vld_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_QRY: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLR: begin
        clr_addr_d = clr_addr_q + LW'(1);
        if (clr_addr_q == LAST_LABEL) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_hit) begin
      if (cfg_idx_i == lgbc_pkg::CFG_NUM_ROWS) begin
        num_rows_d = cfg_rows;
      end else begin
        num_cols_d = cfg_cols;
      end
      cur_row_d = '0;
      cur_col_d = '0;
      slot_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      num_rows_q  <= ROW_RST;
      num_cols_q  <= COL_RST;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      slot_q      <= '0;
      rd_k_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_j_q      <= '0;
      cand_vld_q  <= 1'b0;
      hrd_vld_q   <= 1'b0;
      wr_vld_q    <= 1'b0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      num_rows_q  <= num_rows_d;
      num_cols_q  <= num_cols_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      slot_q      <= slot_d;
      rd_k_q      <= rd_k_d;
      rd_vld_q    <= rd_issue;
      rd_j_q      <= rd_k_q;
      cand_vld_q  <= cand_vld_d;
      hrd_vld_q   <= cand_vld_q;
      wr_vld_q    <= hrd_vld_q;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      win_l_q <= win_c_q;
      win_c_q <= row_rdata_q;
    end
    cand_lab_q <= cand_lab_d;
    hrd_lab_q  <= cand_lab_q;
    wr_lab_q   <= hrd_lab_q;
    wr_data_q  <= inc_cnt;
    if (is_read) begin
      qry_ok_q <= 32'(query_label_i) < MAX_LABELS;
    end
    if (out_load) begin
      border_count_q  <= qry_ok_q ? hist_rdata_q : '0;
      grid_complete_q <= grid_full;
    end
  end

  // row memory: one 3-lane word per column, lane write on push
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      row_mem[row_waddr][slot_q] <= push_lab;
    end
    if (rd_issue) begin
      row_rdata_q <= row_mem[row_raddr];
    end
  end

  // border histogram
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rdata_q <= hist_mem[hist_raddr];
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE) || (dummy_unused_cw != dummy_unused_cw);
  assign out_valid_o     = out_valid_q;
  assign border_count_o  = border_count_q;
  assign grid_complete_o = grid_complete_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!rd_vld_q && !cand_vld_q && !hrd_vld_q))
    else $error("evaluation pipeline busy while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_col_q < num_cols_q)
    else $error("column position beyond configured width");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hrd_vld_q |-> (state_q == ST_EVAL))
    else $error("histogram update outside evaluation pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_QRY))
    else $error("result without a read");
`endif

endmodule

// File: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lgbc_pkg::*;

  localparam int MAX_ROWS      = 64;
  localparam int MAX_COLS      = 64;
  localparam int MAX_LABELS    = 256;
  localparam int SETTLE_CYCLES = MAX_LABELS + MAX_COLS + 16;
  localparam int HOLD_CYCLES   = 200;
  localparam int CROWD_READS   = 40;
  localparam int RANDOM_BEATS  = 1650;
  localparam int REPORT_CAP    = 200;
  localparam int SAT_ROWS      = 40;
  localparam logic [LABEL_W-1:0] SAT_LABEL = 9'd9;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

  typedef struct packed {
    logic               is_reg;
    logic [1:0]         code;
    logic [LABEL_W-1:0] label;
    logic [QUERY_W-1:0] query;
    logic [CFG_W-1:0]   value;
    logic               pinned;
    logic [COUNT_W-1:0] count;
    logic               done;
  } opening_row_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               done;
  } tally_read_t;

  localparam int OPEN_ROWS = 23;
  localparam opening_row_t [0:OPEN_ROWS-1] OPENING = {
    {1'b0, OP_READ,      9'h000, 8'h00, 7'd0,   1'b1, 12'd0, 1'b0},
    {1'b0, OP_READ,      9'h000, 8'hFF, 7'd0,   1'b1, 12'd0, 1'b0},
    {1'b0, OP_NOP,       9'h1FF, 8'hFF, 7'd0,   1'b0, 12'd0, 1'b0},
    {1'b1, CFG_NUM_ROWS, 9'h000, 8'h00, 7'd0,   1'b0, 12'd0, 1'b0},
    {1'b1, CFG_NUM_COLS, 9'h000, 8'h00, 7'd1,   1'b0, 12'd0, 1'b0},
    {1'b0, OP_PUSH,      9'h0FF, 8'h00, 7'd0,   1'b0, 12'd0, 1'b0},
    {1'b0, OP_PUSH,      9'h1FF, 8'h00, 7'd0,   1'b0, 12'd0, 1'b0},
    {1'b0, OP_PUSH,      9'h0FF, 8'h00, 7'd0,   1'b0, 12'd0, 1'b0},
    {1'b0, OP_PUSH,      9'h100, 8'h00, 7'd0,   1'b0, 12'd0, 1'b0},
    {1'b0, OP_PUSH,      9'h000, 8'h00, 7'd0,   1'b0, 12'd0, 1'b0},
    {1'b0, OP_PUSH,      9'h0FF, 8'h00, 7'd0,   1'b0, 12'd0, 1'b0},
    {1'b0, OP_PUSH,      9'h005, 8'h00, 7'd0,   1'b0, 12'd0, 1'b0},
    {1'b0, OP_READ,      9'h000, 8'hFF, 7'd0,   1'b0, 12'd0, 1'b0},
    {1'b0, OP_READ,      9'h000, 8'h00, 7'd0,   1'b0, 12'd0, 1'b0},
    {1'b0, OP_READ,      9'h000, 8'h05, 7'd0,   1'b1, 12'd0, 1'b1},
    {1'b0, OP_CLEAR,     9'h000, 8'h00, 7'd0,   1'b0, 12'd0, 1'b0},
    {1'b0, OP_READ,      9'h000, 8'hFF, 7'd0,   1'b1, 12'd0, 1'b0},
    {1'b1, CFG_UNUSED_LO, 9'h000, 8'h00, 7'd127, 1'b0, 12'd0, 1'b0},
    {1'b1, CFG_UNUSED_HI, 9'h000, 8'h00, 7'd0,   1'b0, 12'd0, 1'b0},
    {1'b1, CFG_NUM_ROWS, 9'h000, 8'h00, 7'd127, 1'b0, 12'd0, 1'b0},
    {1'b1, CFG_NUM_COLS, 9'h000, 8'h00, 7'd127, 1'b0, 12'd0, 1'b0},
    {1'b0, OP_PUSH,      9'h0AA, 8'h55, 7'd0,   1'b0, 12'd0, 1'b0},
    {1'b0, OP_READ,      9'h155, 8'h55, 7'd0,   1'b1, 12'd0, 1'b0}
  };

  logic                       clk_i;
  logic                       rst_ni        = 1'b0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 op_i          = OP_NOP;
  logic signed [LABEL_W-1:0]  cell_label_i  = '0;
  logic [QUERY_W-1:0]         query_label_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i   = 1'b0;
  logic [COUNT_W-1:0]         border_count_o;
  logic                       grid_complete_o;
  logic                       cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i     = '0;
  logic [CFG_W-1:0]           cfg_data_i    = '0;

  logic                       pin_on        = 1'b0;
  logic [COUNT_W-1:0]         pin_count     = '0;
  logic                       pin_done      = 1'b0;
  logic                       quiet         = 1'b0;
  logic                       hold_req      = 1'b0;

  logic [LABEL_W-1:0] row_buf [LANES][MAX_COLS];
  logic [COUNT_W-1:0] border_tally [MAX_LABELS];
  int unsigned        rows_cfg = MAX_ROWS;
  int unsigned        cols_cfg = MAX_COLS;
  int unsigned        row_pos  = 0;
  int unsigned        col_pos  = 0;

  tally_read_t        pending_reads [$];
  int unsigned        mismatches = 0;
  int unsigned        live_beats = 0;

  label_grid_border_counter #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_LABELS (MAX_LABELS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .cell_label_i    (cell_label_i),
    .query_label_i   (query_label_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .border_count_o  (border_count_o),
    .grid_complete_o (grid_complete_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    for (int s = 0; s < LANES; s++) begin
      for (int c = 0; c < MAX_COLS; c++) begin
        row_buf[s][c] = '0;
      end
    end
    for (int l = 0; l < MAX_LABELS; l++) begin
      border_tally[l] = '0;
    end
  end

  function automatic void score_row(int unsigned r);
    int unsigned        up;
    int unsigned        mid;
    int unsigned        dn;
    int unsigned        lc;
    int unsigned        rc;
    logic [LABEL_W-1:0] lab;
    logic               edge_cell;
    up  = (r + 2) % 3;
    mid = r % 3;
    dn  = (r + 1) % 3;
    for (int unsigned c = 0; c < cols_cfg; c++) begin
      lc  = (c == 0) ? cols_cfg - 1 : c - 1;
      rc  = (c + 1 == cols_cfg) ? 0 : c + 1;
      lab = row_buf[mid][c];
      if (lab != UNLABELED) begin
        edge_cell = lab != row_buf[up][lc] || lab != row_buf[up][c] ||
                    lab != row_buf[up][rc] || lab != row_buf[mid][lc] ||
                    lab != row_buf[mid][rc] || lab != row_buf[dn][lc] ||
                    lab != row_buf[dn][c] || lab != row_buf[dn][rc];
        if (edge_cell && lab < MAX_LABELS && border_tally[lab] < COUNT_MAX) begin
          border_tally[lab] = border_tally[lab] + 1'b1;
        end
      end
    end
  endfunction

  function automatic void model_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    int unsigned v;
    v = val;
    case (idx)
      CFG_NUM_ROWS: begin
        rows_cfg = (v < 3) ? 3 : (v > MAX_ROWS) ? MAX_ROWS : v;
        row_pos  = 0;
        col_pos  = 0;
      end
      CFG_NUM_COLS: begin
        cols_cfg = (v < 2) ? 2 : (v > MAX_COLS) ? MAX_COLS : v;
        row_pos  = 0;
        col_pos  = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic void model_beat(logic [1:0] op, logic [LABEL_W-1:0] label,
                                     logic [QUERY_W-1:0] query);
    logic [LABEL_W-1:0] lab;
    tally_read_t        want;
    case (op)
      OP_PUSH: begin
        lab = label[LABEL_W-1] ? UNLABELED : label;
        if (row_pos < rows_cfg) begin
          row_buf[row_pos % 3][col_pos] = lab;
          col_pos++;
          if (col_pos >= cols_cfg) begin
            col_pos = 0;
            if (row_pos >= 2) score_row(row_pos - 1);
            row_pos++;
          end
        end
      end
      OP_READ: begin
        if (pin_on) begin
          want.count = pin_count;
          want.done  = pin_done;
        end else begin
          want.count = border_tally[query];
          want.done  = row_pos >= rows_cfg;
        end
        pending_reads.push_back(want);
      end
      OP_CLEAR: begin
        for (int l = 0; l < MAX_LABELS; l++) begin
          border_tally[l] = '0;
        end
        row_pos = 0;
        col_pos = 0;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin : monitor
    tally_read_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_reads.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= REPORT_CAP) begin
            $display("%0t: unexpected result, expected none, actual count %0d complete %0b",
                     $time, border_count_o, grid_complete_o);
          end
        end else begin
          want = pending_reads.pop_front();
          if (border_count_o !== want.count) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_CAP) begin
              $display("%0t: border_count expected %0d actual %0d",
                       $time, want.count, border_count_o);
            end
          end
          if (grid_complete_o !== want.done) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_CAP) begin
              $display("%0t: grid_complete expected %0b actual %0b",
                       $time, want.done, grid_complete_o);
            end
          end
        end
      end
      if (cfg_we_i) model_register(cfg_idx_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) model_beat(op_i, cell_label_i, query_label_i);
    end
  end

  initial begin : receiver
    int unsigned burst_left;
    int unsigned hold_left;
    burst_left = 0;
    hold_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst_left != 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic offer_beat(op_e op, logic [LABEL_W-1:0] label, logic [QUERY_W-1:0] query,
                            logic pinned, logic [COUNT_W-1:0] cnt, logic done);
    in_valid_i    <= 1'b1;
    op_i          <= op;
    cell_label_i  <= label;
    query_label_i <= query;
    pin_on        <= pinned;
    pin_count     <= cnt;
    pin_done      <= done;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op != OP_NOP) live_beats++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic offer_push(logic [LABEL_W-1:0] label);
    offer_beat(OP_PUSH, label, QUERY_W'($urandom), 1'b0, '0, 1'b0);
  endtask

  task automatic offer_read(logic [QUERY_W-1:0] query);
    offer_beat(OP_READ, LABEL_W'($urandom), query, 1'b0, '0, 1'b0);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic saturate_label();
    logic [LABEL_W-1:0] dot;
    write_register(CFG_NUM_COLS, 7'(MAX_COLS));
    write_register(CFG_NUM_ROWS, 7'(SAT_ROWS));
    for (int g = 0; g < 2; g++) begin
      if (g != 0) write_register(CFG_NUM_ROWS, 7'(SAT_ROWS));
      for (int r = 0; r < SAT_ROWS; r++) begin
        for (int c = 0; c < MAX_COLS; c++) begin
          if (r % 3 == 1 && c % 3 == 1) begin
            if ($urandom_range(0, 1) == 0) dot = {1'b1, 8'($urandom)};
            else dot = LABEL_W'($urandom_range(10, 255));
            offer_push(dot);
          end else begin
            offer_push(SAT_LABEL);
          end
        end
      end
      offer_read(SAT_LABEL[QUERY_W-1:0]);
    end
    offer_beat(OP_READ, '0, SAT_LABEL[QUERY_W-1:0], 1'b1, COUNT_MAX, 1'b1);
  endtask

  task automatic crowd_reads();
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    repeat (CROWD_READS) offer_read(QUERY_W'($urandom));
  endtask

  task automatic grid_phase(bit tidy);
    int unsigned        rows;
    int unsigned        cols;
    logic [LABEL_W-1:0] pool [3];
    logic [LABEL_W-1:0] lab;
    logic [LABEL_W-1:0] last_lab;
    logic [QUERY_W-1:0] query;
    case ($urandom_range(0, 7))
      0: begin rows = 3;  cols = 2;  end
      1: begin rows = 64; cols = 2;  end
      2: begin rows = 3;  cols = 64; end
      default: begin
        rows = $urandom_range(3, 8);
        cols = $urandom_range(2, 12);
      end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      write_register($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI, CFG_W'($urandom));
    end
    write_register(CFG_NUM_ROWS, rows == 3 ? $urandom_range(0, 3) :
                                 rows == 64 ? $urandom_range(64, 127) : rows);
    write_register(CFG_NUM_COLS, cols == 2 ? $urandom_range(0, 2) :
                                 cols == 64 ? $urandom_range(64, 127) : cols);
    pool[0]  = LABEL_W'($urandom_range(0, 255));
    pool[1]  = LABEL_W'($urandom_range(0, 255));
    pool[2]  = UNLABELED;
    last_lab = pool[0];
    for (int k = 0; k < rows * cols; k++) begin
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 3) == 0) query = QUERY_W'($urandom);
        else query = pool[$urandom_range(0, 1)][QUERY_W-1:0];
        offer_read(query);
      end
      if (!tidy) begin
        case ($urandom_range(0, 29))
          0: offer_beat(OP_CLEAR, LABEL_W'($urandom), QUERY_W'($urandom), 1'b0, '0, 1'b0);
          1: offer_beat(OP_NOP, LABEL_W'($urandom), QUERY_W'($urandom), 1'b0, '0, 1'b0);
          default: ;
        endcase
      end
      if (!tidy && $urandom_range(0, 3) == 0) lab = LABEL_W'($urandom);
      else if ($urandom_range(0, 2) != 0) lab = last_lab;
      else lab = pool[$urandom_range(0, 2)];
      last_lab = lab;
      offer_push(lab);
    end
    repeat ($urandom_range(0, 2)) offer_push(LABEL_W'($urandom));
    repeat ($urandom_range(1, 3)) offer_read(pool[$urandom_range(0, 1)][QUERY_W-1:0]);
    if ($urandom_range(0, 5) == 0) begin
      offer_beat(OP_CLEAR, LABEL_W'($urandom), QUERY_W'($urandom), 1'b0, '0, 1'b0);
    end
  endtask

  initial begin : stimulus
    opening_row_t step;
    int unsigned  base;
    int unsigned  phase;
    @(posedge rst_ni);
    @(posedge clk_i);

    for (int i = 0; i < OPEN_ROWS; i++) begin
      step = OPENING[i];
      if (step.is_reg) begin
        write_register(step.code, step.value);
      end else begin
        offer_beat(op_e'(step.code), step.label, step.query, step.pinned, step.count,
                   step.done);
      end
    end

    saturate_label();

    base  = live_beats;
    phase = 0;
    while (live_beats - base < RANDOM_BEATS) begin
      if (live_beats - base >= RANDOM_BEATS * 17 / 20) quiet <= 1'b1;
      if (phase == 3) crowd_reads();
      grid_phase($urandom_range(0, 3) != 0);
      phase++;
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
